// ===== rtl/core/laser_point_gap_fill_packer_unit_macros.svh =====
// assertion macros used by the port-level checker of the packer unit
`ifndef LASER_POINT_GAP_FILL_PACKER_UNIT_MACROS_SVH
`define LASER_POINT_GAP_FILL_PACKER_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define LPGF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpgf: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define LPGF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpgf: next-cycle check failed");

`endif

// ===== rtl/core/lpgf_pkg.sv =====
// shared types and constants of the laser point gap-fill packer
`default_nettype none

package lpgf_pkg;

    // parameter defaults
    localparam int GapLimitDef = 4;
    localparam int MaxFillDef  = 56;
    localparam int FracBitsDef = 16;

    // fixed field widths
    localparam int CoordW = 16;
    localparam int ByteW  = 8;

    // packet constants
    localparam logic [ByteW-1:0]  FillSpare     = 8'hFF;
    localparam logic [ByteW-1:0]  OriginSpare   = 8'hFF;
    localparam logic [ByteW-1:0]  DarkIntensity = 8'h00;
    localparam logic [CoordW-1:0] OriginCoord   = 16'd0;
    localparam logic [CoordW-1:0] DeflectOffset = 16'd32768;
    localparam logic [CoordW-1:0] ScaleReset    = 16'd256;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCALE     = 2'd0,
        CFG_FILL_ALL  = 2'd1,
        CFG_FILL_DARK = 2'd2
    } cfg_idx_t;

    // input command codes
    typedef enum logic {
        CMD_POINT = 1'b0,
        CMD_EOF   = 1'b1
    } cmd_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SRC,
        BK_NGO,
        BK_XGO,
        BK_XWAIT,
        BK_YGO,
        BK_YWAIT,
        BK_FILL,
        BK_ORG1,
        BK_ORG2
    } back_state_t;

    // classified job handed from front to back
    typedef struct packed {
        logic              is_eof;
        logic              emit_src;
        logic [CoordW-1:0] src_x;
        logic [CoordW-1:0] src_y;
        logic [ByteW-1:0]  src_int;
        logic [ByteW-1:0]  src_spare;
        logic [ByteW-1:0]  dst_int;
        logic              do_fill;
        logic [CoordW-1:0] gap;
        logic [CoordW-1:0] dx;
        logic [CoordW-1:0] dy;
        logic              x_up;
        logic              y_up;
    } job_t;

    // raw output point before scaling
    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [ByteW-1:0]  inten;
        logic [ByteW-1:0]  spare;
        logic              last;
    } pt_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpgf_fifo.sv =====
// small register queue between the front and back parts
`default_nettype none

module lpgf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  full,
    output logic                  empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LastPtr = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign full    = (cnt_reg == FullCnt);
    assign empty   = (cnt_reg == CW'(0));
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? AW'(0) : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? AW'(0) : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lpgf_front.sv =====
// front part: accepts items, holds the previous point, classifies the work
`default_nettype none

module lpgf_front #(
    parameter int GAP_LIMIT = lpgf_pkg::GapLimitDef
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    output logic                             item_ready,
    input  wire logic                        command,
    input  wire logic [lpgf_pkg::CoordW-1:0] pos_x,
    input  wire logic [lpgf_pkg::CoordW-1:0] pos_y,
    input  wire logic [lpgf_pkg::ByteW-1:0]  intensity,
    input  wire logic [lpgf_pkg::ByteW-1:0]  spare_byte,
    input  wire logic                        fill_all,
    input  wire logic                        fill_dark,
    input  wire logic                        q_full,
    output logic                             q_push,
    output lpgf_pkg::job_t                   job
);

    localparam logic [lpgf_pkg::CoordW-1:0] GapLim = lpgf_pkg::CoordW'(GAP_LIMIT);

    logic [lpgf_pkg::CoordW-1:0] held_x_reg, held_y_reg;
    logic [lpgf_pkg::ByteW-1:0]  held_int_reg, held_spare_reg;
    logic                        have_reg, have_next;
    logic [lpgf_pkg::CoordW-1:0] dx, dy, gap;
    logic                        x_up, y_up, big_gap, want_fill;

    assign item_ready = !q_full;
    assign q_push     = item_valid && !q_full;

    // distance to the new point on each axis
    always_comb
    begin
        x_up      = (pos_x >= held_x_reg);
        y_up      = (pos_y >= held_y_reg);
        dx        = x_up ? (pos_x - held_x_reg) : (held_x_reg - pos_x);
        dy        = y_up ? (pos_y - held_y_reg) : (held_y_reg - pos_y);
        gap       = (dx > dy) ? dx : dy;
        big_gap   = (gap > GapLim);
        want_fill = fill_all || (fill_dark && (intensity == lpgf_pkg::DarkIntensity));
    end

    // job classification
    always_comb
    begin
        job.is_eof    = (command == lpgf_pkg::CMD_EOF);
        job.emit_src  = 1'b1;
        job.src_x     = held_x_reg;
        job.src_y     = held_y_reg;
        job.src_int   = held_int_reg;
        job.src_spare = held_spare_reg;
        job.dst_int   = intensity;
        job.do_fill   = 1'b0;
        job.gap       = gap;
        job.dx        = dx;
        job.dy        = dy;
        job.x_up      = x_up;
        job.y_up      = y_up;
        have_next     = have_reg;
        if (command == lpgf_pkg::CMD_EOF)
        begin
            job.emit_src = have_reg;
            have_next    = 1'b0;
        end
        else if (!have_reg)
        begin
            // first point of a frame goes out blanked
            job.src_x     = pos_x;
            job.src_y     = pos_y;
            job.src_int   = lpgf_pkg::DarkIntensity;
            job.src_spare = spare_byte;
            have_next     = 1'b1;
        end
        else
        begin
            job.do_fill = want_fill && big_gap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_int_reg   <= '0;
            held_spare_reg <= '0;
            have_reg       <= 1'b0;
        end
        else if (q_push)
        begin
            have_reg <= have_next;
            if (command == lpgf_pkg::CMD_POINT)
            begin
                held_x_reg     <= pos_x;
                held_y_reg     <= pos_y;
                held_int_reg   <= intensity;
                held_spare_reg <= spare_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lpgf_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none

module lpgf_div #(
    parameter int NW = 32,
    parameter int DW = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] numer,
    input  wire logic [DW-1:0] denom,
    output logic               busy,
    output logic      [NW-1:0] quot
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [DW:0]     trial, diff;
    logic            ge;

    assign busy = busy_reg;
    assign quot = quo_reg;

    // one trial subtraction per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[NW-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = numer;
            rem_next  = '0;
            cnt_next  = CNTW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[NW-2:0], ge};
            rem_next  = ge ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next  = cnt_reg - CNTW'(1);
            busy_next = (cnt_reg != CNTW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            den_reg <= denom;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lpgf_back.sv =====
// back part: runs each job, computes fill steps and emits raw points
`default_nettype none

module lpgf_back #(
    parameter int GAP_LIMIT = lpgf_pkg::GapLimitDef,
    parameter int MAX_FILL  = lpgf_pkg::MaxFillDef,
    parameter int FRAC_BITS = lpgf_pkg::FracBitsDef
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    output logic                q_pop,
    input  wire lpgf_pkg::job_t job_in,
    output logic                raw_valid,
    input  wire logic           raw_ready,
    output lpgf_pkg::pt_t       raw
);

    localparam int NW     = lpgf_pkg::CoordW + FRAC_BITS;
    localparam int DivMax = MAX_FILL + 1;
    localparam int DW     = $clog2(DivMax + 1);
    localparam int CW     = $clog2(MAX_FILL + 1);
    // gap / GAP_LIMIT by reciprocal multiplication, exact for every 16-bit gap
    localparam int RecipK = lpgf_pkg::CoordW + $clog2(GAP_LIMIT);
    localparam int MW     = RecipK + 1;
    localparam int GW     = lpgf_pkg::CoordW + MW;
    localparam int QW     = GW - RecipK;
    localparam longint RecipNum = (longint'(1) << RecipK) + longint'(GAP_LIMIT) - 64'sd1;
    localparam logic [MW-1:0] RecipM   = MW'(RecipNum / longint'(GAP_LIMIT));
    localparam logic [QW-1:0] MaxFillQ = QW'(MAX_FILL);
    localparam logic [CW-1:0] MaxFillC = CW'(MAX_FILL);

    lpgf_pkg::back_state_t state_reg, state_next;
    lpgf_pkg::job_t        job_reg;
    lpgf_pkg::pt_t         raw_reg, emit_pt;
    logic                  raw_valid_reg;
    logic [CW-1:0]         n_reg, k_reg;
    logic [NW-1:0]         stepx_reg, stepy_reg, posx_reg, posy_reg;
    logic [NW-1:0]         posx_nxt, posy_nxt;
    logic [GW-1:0]         gap_prod;
    logic [QW-1:0]         n_quot;
    logic                  slot_free, emit, last_fill;
    logic                  div_start, div_busy;
    logic [NW-1:0]         div_numer, div_quot;
    logic [DW-1:0]         div_denom;

    assign raw_valid = raw_valid_reg;
    assign raw       = raw_reg;
    assign slot_free = !raw_valid_reg || raw_ready;
    assign last_fill = ((k_reg + CW'(1)) == n_reg);

    // fill count from the gap
    always_comb
    begin
        gap_prod = GW'(job_reg.gap) * GW'(RecipM);
        n_quot   = gap_prod[GW-1:RecipK];
    end

    // next fill position on each axis
    always_comb
    begin
        posx_nxt = job_reg.x_up ? (posx_reg + stepx_reg) : (posx_reg - stepx_reg);
        posy_nxt = job_reg.y_up ? (posy_reg + stepy_reg) : (posy_reg - stepy_reg);
    end

    // shared divider for both step sizes
    lpgf_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (div_denom),
        .busy  (div_busy),
        .quot  (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lpgf_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (job_in.is_eof && !job_in.emit_src) ?
                                 lpgf_pkg::BK_ORG1 : lpgf_pkg::BK_SRC;
                end
            end
            lpgf_pkg::BK_SRC:
            begin
                if (slot_free)
                begin
                    if (job_reg.is_eof)
                    begin
                        state_next = lpgf_pkg::BK_ORG1;
                    end
                    else if (job_reg.do_fill)
                    begin
                        state_next = lpgf_pkg::BK_NGO;
                    end
                    else
                    begin
                        state_next = lpgf_pkg::BK_IDLE;
                    end
                end
            end
            lpgf_pkg::BK_NGO:   state_next = lpgf_pkg::BK_XGO;
            lpgf_pkg::BK_XGO:   state_next = lpgf_pkg::BK_XWAIT;
            lpgf_pkg::BK_XWAIT: if (!div_busy) state_next = lpgf_pkg::BK_YGO;
            lpgf_pkg::BK_YGO:   state_next = lpgf_pkg::BK_YWAIT;
            lpgf_pkg::BK_YWAIT: if (!div_busy) state_next = lpgf_pkg::BK_FILL;
            lpgf_pkg::BK_FILL:
            begin
                if (slot_free && last_fill)
                begin
                    state_next = lpgf_pkg::BK_IDLE;
                end
            end
            lpgf_pkg::BK_ORG1:  if (slot_free) state_next = lpgf_pkg::BK_ORG2;
            lpgf_pkg::BK_ORG2:  if (slot_free) state_next = lpgf_pkg::BK_IDLE;
            default:            state_next = lpgf_pkg::BK_IDLE;
        endcase
    end

    // outputs per state
    always_comb
    begin
        q_pop         = 1'b0;
        div_start     = 1'b0;
        div_numer     = '0;
        div_denom     = '0;
        emit          = 1'b0;
        emit_pt.x     = lpgf_pkg::OriginCoord;
        emit_pt.y     = lpgf_pkg::OriginCoord;
        emit_pt.inten = lpgf_pkg::DarkIntensity;
        emit_pt.spare = lpgf_pkg::OriginSpare;
        emit_pt.last  = 1'b0;
        case (state_reg)
            lpgf_pkg::BK_IDLE:
            begin
                q_pop = !q_empty;
            end
            lpgf_pkg::BK_SRC:
            begin
                emit          = slot_free;
                emit_pt.x     = job_reg.src_x;
                emit_pt.y     = job_reg.src_y;
                emit_pt.inten = job_reg.src_int;
                emit_pt.spare = job_reg.src_spare;
                emit_pt.last  = !job_reg.is_eof && !job_reg.do_fill;
            end
            lpgf_pkg::BK_XGO:
            begin
                div_start = 1'b1;
                div_numer = {job_reg.dx, {FRAC_BITS{1'b0}}};
                div_denom = DW'(n_reg) + DW'(1);
            end
            lpgf_pkg::BK_YGO:
            begin
                div_start = 1'b1;
                div_numer = {job_reg.dy, {FRAC_BITS{1'b0}}};
                div_denom = DW'(n_reg) + DW'(1);
            end
            lpgf_pkg::BK_FILL:
            begin
                emit          = slot_free;
                emit_pt.x     = posx_nxt[NW-1:FRAC_BITS];
                emit_pt.y     = posy_nxt[NW-1:FRAC_BITS];
                emit_pt.inten = job_reg.dst_int;
                emit_pt.spare = lpgf_pkg::FillSpare;
                emit_pt.last  = last_fill;
            end
            lpgf_pkg::BK_ORG1:
            begin
                emit = slot_free;
            end
            lpgf_pkg::BK_ORG2:
            begin
                emit         = slot_free;
                emit_pt.last = 1'b1;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpgf_pkg::BK_IDLE;
            raw_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                raw_valid_reg <= 1'b1;
            end
            else if (raw_ready)
            begin
                raw_valid_reg <= 1'b0;
            end
        end
    end

    // job, fill run and raw point datapath
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= job_in;
        end
        if (emit)
        begin
            raw_reg <= emit_pt;
        end
        if (state_reg == lpgf_pkg::BK_NGO)
        begin
            n_reg <= (n_quot > MaxFillQ) ? MaxFillC : n_quot[CW-1:0];
        end
        if (state_reg == lpgf_pkg::BK_XWAIT && !div_busy)
        begin
            stepx_reg <= div_quot;
        end
        if (state_reg == lpgf_pkg::BK_YWAIT && !div_busy)
        begin
            stepy_reg <= div_quot;
            posx_reg  <= {job_reg.src_x, {FRAC_BITS{1'b0}}};
            posy_reg  <= {job_reg.src_y, {FRAC_BITS{1'b0}}};
            k_reg     <= '0;
        end
        if (state_reg == lpgf_pkg::BK_FILL && emit)
        begin
            posx_reg <= posx_nxt;
            posy_reg <= posy_nxt;
            k_reg    <= k_reg + CW'(1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/lpgf_scale.sv =====
// output stage: scales coordinates to deflection and holds the result item
`default_nettype none

module lpgf_scale (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic        [lpgf_pkg::CoordW-1:0] scale,
    input  wire logic                               raw_valid,
    output logic                                    raw_ready,
    input  wire lpgf_pkg::pt_t                      raw,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output logic             [lpgf_pkg::ByteW-1:0]  out_intensity,
    output logic             [lpgf_pkg::ByteW-1:0]  out_spare,
    output logic signed      [lpgf_pkg::CoordW-1:0] deflect_x,
    output logic signed      [lpgf_pkg::CoordW-1:0] deflect_y,
    output logic                                    run_last
);

    localparam int PW = 2 * lpgf_pkg::CoordW;

    logic [PW-1:0]                      prod_x, prod_y;
    logic [lpgf_pkg::CoordW-1:0]        defl_x, defl_y;
    logic                               valid_reg;
    logic                               load;
    logic [lpgf_pkg::ByteW-1:0]         int_reg, spare_reg;
    logic signed [lpgf_pkg::CoordW-1:0] dx_reg, dy_reg;
    logic                               last_reg;

    assign raw_ready     = !valid_reg || result_ready;
    assign load          = raw_valid && raw_ready;
    assign result_valid  = valid_reg;
    assign out_intensity = int_reg;
    assign out_spare     = spare_reg;
    assign deflect_x     = dx_reg;
    assign deflect_y     = dy_reg;
    assign run_last      = last_reg;

    // coordinate times scale, centered, wrapped to 16 bits
    always_comb
    begin
        prod_x = PW'(raw.x) * PW'(scale);
        prod_y = PW'(raw.y) * PW'(scale);
        defl_x = prod_x[lpgf_pkg::CoordW-1:0] - lpgf_pkg::DeflectOffset;
        defl_y = prod_y[lpgf_pkg::CoordW-1:0] - lpgf_pkg::DeflectOffset;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (raw_ready)
        begin
            valid_reg <= raw_valid;
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            int_reg   <= raw.inten;
            spare_reg <= raw.spare;
            dx_reg    <= defl_x;
            dy_reg    <= defl_y;
            last_reg  <= raw.last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/laser_point_gap_fill_packer_unit.sv =====
// top level of the laser point gap-fill packer
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   item     | item_valid/item_ready  | command, pos_x, pos_y, intensity, spare_byte
//   result   | result_valid/ready     | out_intensity, out_spare, deflect_x/y, run_last
//   config   | cfg_valid/cfg_ready    | cfg_index, cfg_data
//
// a plain point or a first point passes the job queue, the back job register, the raw
// point register and the result register; the back takes a new job only after the last
// one is done. a gap fill adds the fill count state and two divisions on one shared
// radix-2 divider, then one fill result per cycle while the output is taken.
// end of frame gives two or three results on consecutive cycles while the output is taken.
// a two-entry job queue lets the front keep taking items while the back runs a fill.
// reset is immediate, there is no clearing pass; cfg_ready is always high.
`default_nettype none

module laser_point_gap_fill_packer_unit #(
    parameter int GAP_LIMIT = lpgf_pkg::GapLimitDef,
    parameter int MAX_FILL  = lpgf_pkg::MaxFillDef,
    parameter int FRAC_BITS = lpgf_pkg::FracBitsDef
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_ready,
    input  wire logic                               command,
    input  wire logic        [lpgf_pkg::CoordW-1:0] pos_x,
    input  wire logic        [lpgf_pkg::CoordW-1:0] pos_y,
    input  wire logic        [lpgf_pkg::ByteW-1:0]  intensity,
    input  wire logic        [lpgf_pkg::ByteW-1:0]  spare_byte,
    output logic                                    result_valid,
    input  wire logic                               result_ready,
    output logic             [lpgf_pkg::ByteW-1:0]  out_intensity,
    output logic             [lpgf_pkg::ByteW-1:0]  out_spare,
    output logic signed      [lpgf_pkg::CoordW-1:0] deflect_x,
    output logic signed      [lpgf_pkg::CoordW-1:0] deflect_y,
    output logic                                    run_last,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic        [1:0]                  cfg_index,
    input  wire logic        [lpgf_pkg::CoordW-1:0] cfg_data
);

    localparam int JW = $bits(lpgf_pkg::job_t);

    logic [lpgf_pkg::CoordW-1:0] scale_reg;
    logic                        fill_all_reg, fill_dark_reg;
    logic                        q_push, q_pop, q_full, q_empty;
    lpgf_pkg::job_t              job_w, job_r;
    logic [JW-1:0]               q_rd;
    logic                        raw_valid, raw_ready;
    lpgf_pkg::pt_t               raw;

    assign cfg_ready = 1'b1;
    assign job_r     = lpgf_pkg::job_t'(q_rd);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= lpgf_pkg::ScaleReset;
            fill_all_reg  <= 1'b0;
            fill_dark_reg <= 1'b1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                lpgf_pkg::CFG_SCALE:     scale_reg     <= cfg_data;
                lpgf_pkg::CFG_FILL_ALL:  fill_all_reg  <= cfg_data[0];
                lpgf_pkg::CFG_FILL_DARK: fill_dark_reg <= cfg_data[0];
                default:                 scale_reg     <= scale_reg;
            endcase
        end
    end

    lpgf_front #(
        .GAP_LIMIT (GAP_LIMIT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .command    (command),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .intensity  (intensity),
        .spare_byte (spare_byte),
        .fill_all   (fill_all_reg),
        .fill_dark  (fill_dark_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .job        (job_w)
    );

    lpgf_fifo #(
        .WIDTH (JW),
        .DEPTH (2)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (job_w),
        .pop     (q_pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    lpgf_back #(
        .GAP_LIMIT (GAP_LIMIT),
        .MAX_FILL  (MAX_FILL),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .job_in    (job_r),
        .raw_valid (raw_valid),
        .raw_ready (raw_ready),
        .raw       (raw)
    );

    lpgf_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .scale         (scale_reg),
        .raw_valid     (raw_valid),
        .raw_ready     (raw_ready),
        .raw           (raw),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .out_intensity (out_intensity),
        .out_spare     (out_spare),
        .deflect_x     (deflect_x),
        .deflect_y     (deflect_y),
        .run_last      (run_last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/lpgf_checker.sv =====
// port-level checks of the packer unit and their binding
`default_nettype none
`include "laser_point_gap_fill_packer_unit_macros.svh"

module lpgf_checker (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               item_valid,
    input wire logic                               item_ready,
    input wire logic                               result_valid,
    input wire logic                               result_ready,
    input wire logic signed [lpgf_pkg::CoordW-1:0] deflect_x,
    input wire logic                               run_last,
    input wire logic                               cfg_valid,
    input wire logic                               cfg_ready
);

    // items accepted whose final result has not yet gone out
    logic [3:0] pend_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + 4'((item_valid && item_ready) ? 1 : 0)
                                 - 4'((result_valid && result_ready && run_last) ? 1 : 0);
        end
    end

    `LPGF_ASSERT_NOW(a_cfg_always_ready, clk, rst_n, cfg_valid, cfg_ready)
    `LPGF_ASSERT_NOW(a_result_has_item, clk, rst_n, result_valid, pend_reg != 4'd0)
    `LPGF_ASSERT_NEXT(a_result_held, clk, rst_n, result_valid && !result_ready, result_valid)
    `LPGF_ASSERT_NEXT(a_result_stable, clk, rst_n, result_valid && !result_ready, $stable(deflect_x) && $stable(run_last))

endmodule

bind laser_point_gap_fill_packer_unit lpgf_checker u_lpgf_checker (.*);

`default_nettype wire

// ===== bench/lpgf_packet_checker.sv =====
// checker for the laser point gap-fill packer: predicts result packets and compares them
module lpgf_packet_checker #(
    parameter int GAP_LIMIT = lpgf_pkg::GapLimitDef,
    parameter int MAX_FILL  = lpgf_pkg::MaxFillDef,
    parameter int FRAC_BITS = lpgf_pkg::FracBitsDef
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    input  logic                               item_ready,
    input  logic                               command,
    input  logic        [lpgf_pkg::CoordW-1:0] pos_x,
    input  logic        [lpgf_pkg::CoordW-1:0] pos_y,
    input  logic        [lpgf_pkg::ByteW-1:0]  intensity,
    input  logic        [lpgf_pkg::ByteW-1:0]  spare_byte,
    input  logic                               result_valid,
    input  logic                               result_ready,
    input  logic        [lpgf_pkg::ByteW-1:0]  out_intensity,
    input  logic        [lpgf_pkg::ByteW-1:0]  out_spare,
    input  logic signed [lpgf_pkg::CoordW-1:0] deflect_x,
    input  logic signed [lpgf_pkg::CoordW-1:0] deflect_y,
    input  logic                               run_last,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic        [1:0]                  cfg_index,
    input  logic        [lpgf_pkg::CoordW-1:0] cfg_data,
    output int                                 fault_count,
    output int                                 packets_owed
);
    import lpgf_pkg::*;

    // one output packet as it should appear on the result port
    typedef struct packed {
        logic [ByteW-1:0]  inten;
        logic [ByteW-1:0]  spare;
        logic [CoordW-1:0] dfx;
        logic [CoordW-1:0] dfy;
        logic              last;
    } packet_t;

    packet_t owed_packets[$];

    // shadow of the configuration registers
    logic [CoordW-1:0] scale_reg;
    logic              fill_all_reg;
    logic              fill_dark_reg;

    // shadow of the held point
    logic [CoordW-1:0] held_x;
    logic [CoordW-1:0] held_y;
    logic [ByteW-1:0]  held_int;
    logic [ByteW-1:0]  held_spare;
    logic              have_point;

    // coordinate times scale, minus the offset, wrapped to 16 bits
    function automatic logic [CoordW-1:0] deflect_of(input logic [CoordW-1:0] c);
        logic [31:0] prod;
        prod = 32'(c) * 32'(scale_reg);
        return prod[CoordW-1:0] - DeflectOffset;
    endfunction

    // fixed point position of fill point k of div-1 between two coordinates
    function automatic logic [CoordW-1:0] fill_coord(input logic [CoordW-1:0] from,
                                                     input logic [CoordW-1:0] to,
                                                     input int unsigned k,
                                                     input int unsigned div);
        longint unsigned span;
        longint unsigned stride;
        longint unsigned base;
        longint unsigned pos;
        span   = (from > to) ? 64'(from - to) : 64'(to - from);
        stride = (span << FRAC_BITS) / 64'(div);
        base   = 64'(from) << FRAC_BITS;
        pos    = (to >= from) ? base + 64'(k) * stride : base - 64'(k) * stride;
        return 16'(pos >> FRAC_BITS);
    endfunction

    task automatic owe_packet(input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                              input logic [ByteW-1:0] inten, input logic [ByteW-1:0] spare);
        packet_t pkt;
        pkt.inten = inten;
        pkt.spare = spare;
        pkt.dfx   = deflect_of(x);
        pkt.dfy   = deflect_of(y);
        pkt.last  = 1'b0;
        owed_packets.insert(owed_packets.size(), pkt);
    endtask

    // expected packets for one accepted item, and the new held point
    task automatic build_packets(input cmd_t cmd, input logic [CoordW-1:0] nx,
                                 input logic [CoordW-1:0] ny, input logic [ByteW-1:0] ni,
                                 input logic [ByteW-1:0] ns);
        logic [CoordW-1:0] gx;
        logic [CoordW-1:0] gy;
        logic [CoordW-1:0] gap;
        int unsigned       nfill;
        int unsigned       k;
        if (cmd == CMD_EOF)
        begin
            if (have_point)
                owe_packet(held_x, held_y, held_int, held_spare);
            owe_packet(OriginCoord, OriginCoord, DarkIntensity, OriginSpare);
            owe_packet(OriginCoord, OriginCoord, DarkIntensity, OriginSpare);
            have_point = 1'b0;
        end
        else
        begin
            if (!have_point)
            begin
                // first point of a frame goes out blanked
                owe_packet(nx, ny, DarkIntensity, ns);
            end
            else
            begin
                gx  = (held_x > nx) ? held_x - nx : nx - held_x;
                gy  = (held_y > ny) ? held_y - ny : ny - held_y;
                gap = (gx > gy) ? gx : gy;
                owe_packet(held_x, held_y, held_int, held_spare);
                // fill run toward the new point
                if ((fill_all_reg || fill_dark_reg) && gap > GAP_LIMIT &&
                    (fill_all_reg || ni == DarkIntensity))
                begin
                    nfill = gap / GAP_LIMIT;
                    if (nfill > MAX_FILL)
                        nfill = MAX_FILL;
                    for (k = 1; k <= nfill; k++)
                        owe_packet(fill_coord(held_x, nx, k, nfill + 1),
                                   fill_coord(held_y, ny, k, nfill + 1), ni, FillSpare);
                end
            end
            held_x     = nx;
            held_y     = ny;
            held_int   = ni;
            held_spare = ns;
            have_point = 1'b1;
        end
        owed_packets[$].last = 1'b1;
    endtask

    // compare one accepted result with the oldest owed packet
    task automatic check_result();
        packet_t want;
        if (owed_packets.size() == 0)
        begin
            $error("result arrived with no packet owed");
            fault_count++;
        end
        else
        begin
            want = owed_packets.pop_front();
            if (out_intensity !== want.inten)
            begin
                $error("out_intensity: expected %0d, got %0d", want.inten, out_intensity);
                fault_count++;
            end
            if (out_spare !== want.spare)
            begin
                $error("out_spare: expected %0d, got %0d", want.spare, out_spare);
                fault_count++;
            end
            if (deflect_x !== want.dfx)
            begin
                $error("deflect_x: expected %0d, got %0d", $signed(want.dfx), deflect_x);
                fault_count++;
            end
            if (deflect_y !== want.dfy)
            begin
                $error("deflect_y: expected %0d, got %0d", $signed(want.dfy), deflect_y);
                fault_count++;
            end
            if (run_last !== want.last)
            begin
                $error("run_last: expected %0d, got %0d", want.last, run_last);
                fault_count++;
            end
        end
    endtask

    // watch the three channels
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            scale_reg     = ScaleReset;
            fill_all_reg  = 1'b0;
            fill_dark_reg = 1'b1;
            held_x        = '0;
            held_y        = '0;
            held_int      = '0;
            held_spare    = '0;
            have_point    = 1'b0;
            owed_packets.delete();
        end
        else
        begin
            if (result_valid && result_ready)
                check_result();
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SCALE:     scale_reg = cfg_data;
                    CFG_FILL_ALL:  fill_all_reg = cfg_data[0];
                    CFG_FILL_DARK: fill_dark_reg = cfg_data[0];
                    default:       ;
                endcase
            end
            if (item_valid && item_ready)
                build_packets(cmd_t'(command), pos_x, pos_y, intensity, spare_byte);
        end
        packets_owed = owed_packets.size();
    end

endmodule

// ===== bench/tb.sv =====
// testbench top for the laser point gap-fill packer: stimulus, handshake pacing and verdict
module tb;
    import lpgf_pkg::*;

    localparam int CycleLimit = 800000;
    localparam int DrainCycles = 200;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     item_valid = 1'b0;
    logic                     item_ready;
    logic                     command = 1'b0;
    logic        [CoordW-1:0] pos_x = '0;
    logic        [CoordW-1:0] pos_y = '0;
    logic        [ByteW-1:0]  intensity = '0;
    logic        [ByteW-1:0]  spare_byte = '0;
    logic                     result_valid;
    logic                     result_ready = 1'b0;
    logic        [ByteW-1:0]  out_intensity;
    logic        [ByteW-1:0]  out_spare;
    logic signed [CoordW-1:0] deflect_x;
    logic signed [CoordW-1:0] deflect_y;
    logic                     run_last;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic        [1:0]        cfg_index = '0;
    logic        [CoordW-1:0] cfg_data = '0;

    int fault_count;
    int packets_owed;
    int cycle_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int phase;
    logic [CoordW-1:0] last_x = '0;
    logic [CoordW-1:0] last_y = '0;

    laser_point_gap_fill_packer_unit u_top (.*);

    lpgf_packet_checker u_chk (.*);

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
    begin
        if (stall_pct == 0)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(99) >= stall_pct);
    end

    // offer one item, with a random idle gap first
    task automatic send_item(input cmd_t cmd, input logic [CoordW-1:0] x,
                             input logic [CoordW-1:0] y, input logic [ByteW-1:0] inten,
                             input logic [ByteW-1:0] spare);
        int idle;
        idle = 0;
        while ($urandom_range(99) < gap_pct)
            idle++;
        if (idle > 0)
        begin
            item_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        pos_x      <= x;
        pos_y      <= y;
        intensity  <= inten;
        spare_byte <= spare;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
    endtask

    // stop sending and wait for every owed packet
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (packets_owed != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CoordW-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // write all three registers back to back
    task automatic set_config(input logic [CoordW-1:0] scale, input logic all_gaps,
                              input logic dark_gaps);
        cfg_valid <= 1'b1;
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_FILL_ALL, {15'd0, all_gaps});
        write_reg(CFG_FILL_DARK, {15'd0, dark_gaps});
        cfg_valid <= 1'b0;
    endtask

    // a frame of points, mostly near the previous one, usually closed by end of frame
    task automatic send_random_frame();
        int npts;
        int tx;
        int ty;
        logic [CoordW-1:0] px;
        logic [CoordW-1:0] py;
        logic [ByteW-1:0]  pint;
        npts = $urandom_range(6, 1);
        repeat (npts)
        begin
            if ($urandom_range(99) < 20)
            begin
                px = 16'($urandom);
                py = 16'($urandom);
            end
            else
            begin
                tx = int'(last_x) + int'($urandom_range(80)) - 40;
                ty = int'(last_y) + int'($urandom_range(80)) - 40;
                px = 16'(tx);
                py = 16'(ty);
            end
            pint = ($urandom_range(99) < 40) ? DarkIntensity : 8'($urandom_range(255, 1));
            send_item(CMD_POINT, px, py, pint, 8'($urandom));
            last_x = px;
            last_y = py;
        end
        // sometimes the frame is left open and runs into the next one
        if ($urandom_range(99) < 85)
            send_item(CMD_EOF, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
        // stray end of frame, with nothing held unless the frame was left open
        if ($urandom_range(99) < 10)
            send_item(CMD_EOF, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, dark-only fill
        send_item(CMD_EOF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(CMD_POINT, 16'h0000, 16'h0000, 8'hFF, 8'h00);
        send_item(CMD_POINT, 16'hFFFF, 16'hFFFF, 8'h00, 8'hAA);
        send_item(CMD_POINT, 16'hFFFF, 16'h0000, 8'hC8, 8'h55);
        send_item(CMD_POINT, 16'hFFFF, 16'h0003, 8'h00, 8'h01);
        send_item(CMD_POINT, 16'hFFFF, 16'h0007, 8'h00, 8'h02);
        send_item(CMD_POINT, 16'hFFFF, 16'h000C, 8'h00, 8'h03);
        send_item(CMD_POINT, 16'hFFEB, 16'h002A, 8'h00, 8'h04);
        send_item(CMD_POINT, 16'h0000, 16'h0000, 8'h00, 8'h05);
        send_item(CMD_EOF, 16'h0000, 16'h0000, 8'h00, 8'h00);
        send_item(CMD_EOF, 16'h5A5A, 16'hA5A5, 8'h5A, 8'hA5);
        wait_drained();

        // zero scale with fill on every gap
        set_config(16'd0, 1'b1, 1'b0);
        send_item(CMD_POINT, 16'h1234, 16'h4321, 8'h09, 8'h7E);
        send_item(CMD_POINT, 16'h1200, 16'h4300, 8'h80, 8'h81);
        send_item(CMD_EOF, 16'h0000, 16'h0000, 8'h00, 8'h00);

        // random phases over pacing modes and register settings
        for (phase = 0; phase < 8; phase++)
        begin
            wait_drained();
            case (phase % 4)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 80; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 80; end
                default: begin gap_pct = 7;  stall_pct = 7;  end
            endcase
            case (phase)
                0:       set_config(16'd1, 1'b1, 1'b0);
                1:       set_config(16'hFFFF, 1'b0, 1'b1);
                2:       set_config(16'($urandom_range(65535, 1)), 1'b1, 1'b1);
                3:       set_config(ScaleReset, 1'b0, 1'b0);
                4:       set_config(16'($urandom_range(65535, 1)), 1'b1, 1'b0);
                5:       set_config(16'hFFFF, 1'b1, 1'b1);
                6:       set_config(16'd2, 1'b0, 1'b1);
                default: set_config(16'($urandom_range(65535, 1)), 1'b0, 1'b1);
            endcase
            repeat (3) send_random_frame();
        end

        // drain and let any stray result show up
        wait_drained();
        repeat (DrainCycles) @(posedge clk);
        @(negedge clk);
        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== laser_point_gap_fill_packer_unit.f =====
+incdir+rtl/core
rtl/core/lpgf_pkg.sv
rtl/core/lpgf_fifo.sv
rtl/core/lpgf_front.sv
rtl/core/lpgf_div.sv
rtl/core/lpgf_back.sv
rtl/core/lpgf_scale.sv
rtl/core/laser_point_gap_fill_packer_unit.sv
rtl/core/lpgf_checker.sv
bench/lpgf_packet_checker.sv
bench/tb.sv
